### sv/date_period_overlap_days_defines.svh
// Assertion macros for the date period overlap block.
// Used by date_period_overlap_days.sv; expects clk_i and rst_ni in scope.
`ifndef DATE_PERIOD_OVERLAP_DAYS_DEFINES_SVH
`define DATE_PERIOD_OVERLAP_DAYS_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge, disabled while in reset.
`define DPOD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition now implies a condition in the next cycle.
`define DPOD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define DPOD_ASSERT(lbl, prop, msg)
`define DPOD_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

### sv/dpod_pkg.sv
// Shared constants, types and the month offset table for the overlap block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package dpod_pkg;

  localparam int YEAR_LIMIT = 3000;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;

  localparam int NUM_LANES = 4;

  // Day number and overlap width; 365 * 4095 plus a year's days fits.
  localparam int DN_W  = 21;
  localparam int OVR_W = 21;

  // p / 100 as (p * 5243) >> 19, exact for any 12-bit p.
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_MUL_W = 13;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W       = YEAR_W + DIV100_MUL_W;
  localparam int Q100_W       = 6;

  localparam int CUM_W = 9;

  localparam int MONTH_MAX = 12;

  typedef struct packed {
    logic en_a;  // load first lane stage
    logic en_b;  // load second lane stage
  } lane_ctrl_t;

  // Days before the first of month m in a common year.
  function automatic logic [CUM_W-1:0] month_cum(input logic [MONTH_W-1:0] m);
    logic [CUM_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/date_period_overlap_days.sv
// Top level of the date period overlap block: handshake, config, lanes, merge.
// Depends on dpod_pkg, dpod_lane, dpod_merge, date_period_overlap_days_defines.svh.
//
//  channel   dir  signals                         moves
//  s_axis    in   tvalid tready tdata[87:0]       one pair of periods per transfer
//  m_axis    out  tvalid tready tdata[23:0] tuser one overlap result per transfer
//  cfg       in   cfg_we_i cfg_wdata_i            include_end_day write
//
// One transfer per cycle in and out while m_axis is not stalled; the pipeline
// has two lane stages for the day number conversion and one merge stage.
// Four lanes convert the four dates in parallel; the merge stage takes the
// later start, the earlier end and the difference.
// Reset clears the stage valid bits and sets include_end_day to 1.
// A stall on m_axis holds the pipeline; input keeps flowing until every
// stage is full.
`timescale 1ns / 1ps
`default_nettype none

`include "date_period_overlap_days_defines.svh"

module date_period_overlap_days
  import dpod_pkg::*;
#(
  parameter int YearLimit = YEAR_LIMIT  // years above this saturate
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [11:0] first_start_year, [15:12] first_start_month, [20:16] first_start_day,
  // [32:21] first_end_year, [36:33] first_end_month, [41:37] first_end_day,
  // [53:42] second_start_year, [57:54] second_start_month,
  // [62:58] second_start_day, [74:63] second_end_year,
  // [78:75] second_end_month, [83:79] second_end_day, [87:84] zero
  input  wire logic [87:0] s_axis_tdata,

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [20:0] overlap_days, [23:21] zero
  output logic      [23:0] m_axis_tdata,
  // [0] no_overlap
  output logic      [0:0]  m_axis_tuser,

  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i
);

  // include_end_day register
  logic inc_end_d, inc_end_q;

  assign inc_end_d = cfg_we_i ? cfg_wdata_i : inc_end_q;

  // Stage valids: a = lane stage one, b = lane stage two, c = merge/output
  logic va_d, va_q;
  logic vb_d, vb_q;
  logic vc_d, vc_q;
  logic rdy_a, rdy_b, rdy_c;

  // a stage can load when it is empty or its contents move on this cycle
  assign rdy_c = !vc_q || m_axis_tready;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;

  assign va_d = rdy_a ? s_axis_tvalid : va_q;
  assign vb_d = rdy_b ? va_q : vb_q;
  assign vc_d = rdy_c ? vb_q : vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_end_q <= 1'b1;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      vc_q      <= 1'b0;
    end else begin
      inc_end_q <= inc_end_d;
      va_q      <= va_d;
      vb_q      <= vb_d;
      vc_q      <= vc_d;
    end
  end

  lane_ctrl_t lane_ctrl;

  assign lane_ctrl.en_a = rdy_a && s_axis_tvalid;
  assign lane_ctrl.en_b = rdy_b && va_q;

  // Lane order: first start, first end, second start, second end
  logic [DN_W-1:0] day_num [NUM_LANES];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    localparam int Base = g * DATE_W;

    dpod_lane #(
      .YearLimit (YearLimit)
    ) u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl),
      .year_i    (s_axis_tdata[Base +: YEAR_W]),
      .month_i   (s_axis_tdata[Base + YEAR_W +: MONTH_W]),
      .day_i     (s_axis_tdata[Base + YEAR_W + MONTH_W +: DAY_W]),
      .day_num_o (day_num[g])
    );
  end

  logic [OVR_W-1:0] overlap_days;
  logic             no_overlap;

  dpod_merge u_merge (
    .clk_i          (clk_i),
    .en_i           (rdy_c && vb_q),
    .include_end_i  (inc_end_q),
    .first_start_i  (day_num[0]),
    .first_end_i    (day_num[1]),
    .second_start_i (day_num[2]),
    .second_end_i   (day_num[3]),
    .overlap_days_o (overlap_days),
    .no_overlap_o   (no_overlap)
  );

  assign s_axis_tready   = rdy_a;
  assign m_axis_tvalid   = vc_q;
  assign m_axis_tdata    = {{(24 - OVR_W){1'b0}}, overlap_days};
  assign m_axis_tuser[0] = no_overlap;

  // Disjoint periods always report a zero count
  `DPOD_ASSERT(a_disjoint_zero, (vc_q && no_overlap) |-> (overlap_days == '0), "disjoint with nonzero count")
  // A filled first stage that cannot advance keeps its item
  `DPOD_ASSERT_NEXT(a_hold_a, (va_q && !rdy_b), va_q, "stage a lost an item")
  // Full pipeline with stalled output must refuse new input
  `DPOD_ASSERT(a_full_block, (va_q && vb_q && vc_q && !m_axis_tready) |-> !s_axis_tready, "accepted while full")
  // Output valid only rises after the lane stage held an item
  `DPOD_ASSERT(a_out_src, $rose(vc_q) |-> $past(vb_q), "output from empty stage")

endmodule

`default_nettype wire

### sv/dpod_lane.sv
// One lane: turns a Gregorian date into a day number over two register stages.
// Depends on dpod_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpod_lane
  import dpod_pkg::*;
#(
  parameter int YearLimit = YEAR_LIMIT
) (
  input  wire logic               clk_i,
  input  wire lane_ctrl_t         ctrl_i,
  input  wire logic [YEAR_W-1:0]  year_i,
  input  wire logic [MONTH_W-1:0] month_i,
  input  wire logic [DAY_W-1:0]   day_i,
  output logic      [DN_W-1:0]    day_num_o
);

  // Stage A: clamp, century quotient, month offset
  logic [YEAR_W-1:0]  year_c;
  logic [MONTH_W-1:0] month_c;
  logic [PROD_W-1:0]  prod;

  logic [YEAR_W-1:0]  p_d, p_q;
  logic [Q100_W-1:0]  q100_d, q100_q;
  logic [CUM_W-1:0]   cum_d, cum_q;
  logic [DAY_W-1:0]   day_d, day_q;
  logic               late_d, late_q;

  always_comb begin
    if (year_i == '0) begin
      year_c = YEAR_W'(1);
    end else if (int'(year_i) > YearLimit) begin
      year_c = YEAR_W'(YearLimit);
    end else begin
      year_c = year_i;
    end

    if (month_i == '0) begin
      month_c = MONTH_W'(1);
    end else if (month_i > MONTH_W'(MONTH_MAX)) begin
      month_c = MONTH_W'(MONTH_MAX);
    end else begin
      month_c = month_i;
    end

    p_d    = year_c - YEAR_W'(1);
    prod   = PROD_W'(p_d) * PROD_W'(DIV100_MUL);
    q100_d = prod[DIV100_SHIFT +: Q100_W];
    cum_d  = month_cum(month_c);
    day_d  = day_i;
    late_d = (month_c > MONTH_W'(2));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_a) begin
      p_q    <= p_d;
      q100_q <= q100_d;
      cum_q  <= cum_d;
      day_q  <= day_d;
      late_q <= late_d;
    end
  end

  // Stage B: leap test and day number sum
  logic [YEAR_W-1:0] hund;
  logic [YEAR_W-1:0] r100;
  logic [Q100_W-1:0] cent;
  logic              leap;
  logic [DN_W-1:0]   dn_d, dn_q;

  always_comb begin
    hund = YEAR_W'(q100_q) * YEAR_W'(100);
    r100 = p_q - hund;
    // year = p + 1; its century index is q100 + 1 when the year ends in 00
    cent = q100_q + Q100_W'(1);
    leap = (p_q[1:0] == 2'b11) &&
           ((r100 != YEAR_W'(99)) || (cent[1:0] == 2'b00));
    dn_d = DN_W'(p_q) * DN_W'(365)
         + DN_W'(p_q >> 2)
         - DN_W'(q100_q)
         + DN_W'(q100_q >> 2)
         + DN_W'(cum_q)
         + DN_W'(late_q & leap)
         + DN_W'(day_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_b) begin
      dn_q <= dn_d;
    end
  end

  assign day_num_o = dn_q;

endmodule

`default_nettype wire

### sv/dpod_merge.sv
// Merge stage: later start, earlier end, registered overlap count and flag.
// Depends on dpod_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpod_merge
  import dpod_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             include_end_i,
  input  wire logic [DN_W-1:0]  first_start_i,
  input  wire logic [DN_W-1:0]  first_end_i,
  input  wire logic [DN_W-1:0]  second_start_i,
  input  wire logic [DN_W-1:0]  second_end_i,
  output logic      [OVR_W-1:0] overlap_days_o,
  output logic                  no_overlap_o
);

  logic [DN_W-1:0]  lo, hi;
  logic [OVR_W-1:0] days_d, days_q;
  logic             none_d, none_q;

  always_comb begin
    lo = (first_start_i > second_start_i) ? first_start_i : second_start_i;
    hi = (first_end_i < second_end_i) ? first_end_i : second_end_i;
    if (hi < lo) begin
      days_d = '0;
      none_d = 1'b1;
    end else begin
      days_d = OVR_W'(hi - lo) + OVR_W'(include_end_i);
      none_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      days_q <= days_d;
      none_q <= none_d;
    end
  end

  assign overlap_days_o = days_q;
  assign no_overlap_o   = none_q;

endmodule

`default_nettype wire
